// ----- rtl/core/charge_map_local_maximum_macros.svh -----
// Assertion macros for the checker file of the local maximum block.
`ifndef CHARGE_MAP_LOCAL_MAXIMUM_MACROS_SVH
`define CHARGE_MAP_LOCAL_MAXIMUM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CMLM_ASSERT_IMPLY(label, clk, rst, cond, consequent, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consequent)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CMLM_ASSERT_NEXT(label, clk, rst, cond, consequent, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consequent)) \
      else $error(msg);

`endif

// ----- rtl/core/cmlm_pkg.sv -----
package cmlm_pkg;

   // Register port
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 14;
   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 12;
   localparam int LEVEL_BITS        = 14;

   // Register reset values
   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 12'd160;
   localparam logic [LEVEL_BITS-1:0]        QMAX_CUTOFF_RESET  = 14'd48;
   localparam logic [LEVEL_BITS-1:0]        THRESHOLD_RESET    = 14'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH      = 2'd0,
      REG_FRAME_HEIGHT     = 2'd1,
      REG_QMAX_CUTOFF      = 2'd2,
      REG_CHARGE_THRESHOLD = 2'd3
   } csr_index_type;

   // Row counter runs through the frame plus the flush row
   localparam int ROW_COUNT_BITS = FRAME_HEIGHT_BITS + 1;
   localparam int OUT_ROW_BITS   = 12;
   localparam int OUT_COL_BITS   = 10;
   localparam int RSP_DATA_BITS  = 24;

   // Output queue
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   // Result item, is_peak in bit 0
   typedef struct packed {
      logic [OUT_COL_BITS-1:0] out_column;
      logic [OUT_ROW_BITS-1:0] out_row;
      logic                    above_threshold;
      logic                    is_peak;
   } result_type;

endpackage

// ----- rtl/core/cmlm_ram.sv -----
module cmlm_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cmlm_cell.sv -----
module cmlm_cell #(
   parameter int CHARGE_BITS = 14
) (
   input  logic                        clock,
   input  logic                        shift,
   input  logic                        kill,
   input  logic [2:0][CHARGE_BITS-1:0] col_in,
   output logic [2:0][CHARGE_BITS-1:0] col_out
);

   // One window column: top, middle and bottom charge
   logic [2:0][CHARGE_BITS-1:0] col_ff;
   logic [2:0][CHARGE_BITS-1:0] col_in_next;

   // Take the neighbor's column, or zeros at the start of a row
   always_comb begin
      col_in_next = kill ? '0 : col_in;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in_next;
      end
   end

   assign col_out = col_ff;

endmodule

// ----- rtl/core/charge_map_local_maximum.sv -----
// A request is registered, looked up in the line RAM and judged in the next cycle, and its
// result enters the result queue, from which rsp offers it. A pixel's result is completed
// by the request of its bottom-right neighbor (W+1 requests later). Throughput: one request
// per cycle while the result queue has room, held by the line RAM (one read, one write per
// cycle) and the four-entry result queue. Synchronous reset clears counters, queue and
// registers to their defaults; the line RAM keeps its contents and needs no clearing pass.
module charge_map_local_maximum #(
   parameter int MAX_WIDTH   = 1024,
   parameter int CHARGE_BITS = 14,
   localparam int ReqDataBits = ((CHARGE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ReqDataBits-1:0]              req_tdata,   // charge
   input  logic [0:0]                          req_tuser,   // filler
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // is_peak, above_threshold, out_row, out_column
   output logic [cmlm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmlm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cmlm_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int ColBits    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RowBits    = cmlm_pkg::ROW_COUNT_BITS;
   localparam int FwBits     = cmlm_pkg::FRAME_WIDTH_BITS;
   localparam int FhBits     = cmlm_pkg::FRAME_HEIGHT_BITS;
   localparam int LvlBits    = cmlm_pkg::LEVEL_BITS;
   localparam int OutRowBits = cmlm_pkg::OUT_ROW_BITS;
   localparam int OutColBits = cmlm_pkg::OUT_COL_BITS;
   localparam int CmpBits    = (CHARGE_BITS > LvlBits) ? CHARGE_BITS : LvlBits;
   localparam int CntBits    = cmlm_pkg::QUEUE_COUNT_BITS;
   localparam int PtrBits    = cmlm_pkg::QUEUE_PTR_BITS;

   typedef logic [2:0][CHARGE_BITS-1:0] column_type;

   // ---------------------------------------------------------------- registers
   logic [FwBits-1:0]  frame_width_ff;
   logic [FhBits-1:0]  frame_height_ff;
   logic [LvlBits-1:0] qmax_cutoff_ff;
   logic [LvlBits-1:0] threshold_ff;
   logic               csr_write;
   logic               geometry_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign geometry_write = csr_write &&
      (cmlm_pkg::csr_index_type'(csr_index) == cmlm_pkg::REG_FRAME_WIDTH ||
       cmlm_pkg::csr_index_type'(csr_index) == cmlm_pkg::REG_FRAME_HEIGHT);

   // Store register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= cmlm_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= cmlm_pkg::FRAME_HEIGHT_RESET;
         qmax_cutoff_ff  <= cmlm_pkg::QMAX_CUTOFF_RESET;
         threshold_ff    <= cmlm_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (cmlm_pkg::csr_index_type'(csr_index))
            cmlm_pkg::REG_FRAME_WIDTH:      frame_width_ff  <= csr_data[FwBits-1:0];
            cmlm_pkg::REG_FRAME_HEIGHT:     frame_height_ff <= csr_data[FhBits-1:0];
            cmlm_pkg::REG_QMAX_CUTOFF:      qmax_cutoff_ff  <= csr_data[LvlBits-1:0];
            cmlm_pkg::REG_CHARGE_THRESHOLD: threshold_ff    <= csr_data[LvlBits-1:0];
         endcase
      end
   end

   // Clamp the geometry: last column index and effective height
   logic [ColBits-1:0] col_last;
   logic [FhBits-1:0]  height_eff;

   always_comb begin
      if (frame_width_ff < FwBits'(3)) begin
         col_last = ColBits'(2);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         col_last = ColBits'(MAX_WIDTH - 1);
      end else begin
         col_last = ColBits'(frame_width_ff - FwBits'(1));
      end
      height_eff = (frame_height_ff == '0) ? FhBits'(1) : frame_height_ff;
   end

   // ---------------------------------------------------------------- raster position
   logic               accept;
   logic [ColBits-1:0] col_ff;
   logic [RowBits-1:0] row_ff;
   logic               first_col;
   logic               frame_done;

   assign accept     = req_tvalid && req_tready;
   assign first_col  = (col_ff == '0);
   assign frame_done = (row_ff > RowBits'(height_eff));

   // Advance column and row per request; restart after the flush position, on reset or on a geometry write
   always_ff @(posedge clock) begin
      if (reset || geometry_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         priority if (frame_done) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_ff == col_last) begin
            col_ff <= '0;
            row_ff <= row_ff + RowBits'(1);
         end else begin
            col_ff <= col_ff + ColBits'(1);
         end
      end
   end

   // ---------------------------------------------------------------- stage 1 capture
   logic [CHARGE_BITS-1:0] x_in;
   logic [RowBits-1:0]     out_row_full;
   logic [ColBits-1:0]     out_col_full;

   always_comb begin
      x_in = (row_ff < RowBits'(height_eff) && !req_tuser[0]) ?
             req_tdata[CHARGE_BITS-1:0] : '0;
      out_row_full = first_col ? row_ff - RowBits'(2) : row_ff - RowBits'(1);
      out_col_full = first_col ? col_last : col_ff - ColBits'(1);
   end

   logic                   s1_valid_ff;
   logic [CHARGE_BITS-1:0] s1_x_ff;
   logic [ColBits-1:0]     s1_col_ff;
   logic                   s1_use_a_ff;
   logic                   s1_use_b_ff;
   logic                   s1_first_ff;
   logic                   s1_emit_ff;
   logic [OutRowBits-1:0]  s1_out_row_ff;
   logic [OutColBits-1:0]  s1_out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // Hold the pixel and its position while the line RAM answers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff       <= x_in;
         s1_col_ff     <= col_ff;
         s1_use_a_ff   <= (row_ff >= RowBits'(2));
         s1_use_b_ff   <= (row_ff >= RowBits'(1));
         s1_first_ff   <= first_col;
         s1_emit_ff    <= first_col ? (row_ff >= RowBits'(2)) : (row_ff >= RowBits'(1));
         s1_out_row_ff <= out_row_full[OutRowBits-1:0];
         s1_out_col_ff <= OutColBits'(out_col_full);
      end
   end

   // ---------------------------------------------------------------- line RAM
   // Each entry holds {row two back, row one back} for its column.
   logic [2*CHARGE_BITS-1:0] line_rd_data;
   logic [2*CHARGE_BITS-1:0] line_wr_data;
   logic [CHARGE_BITS-1:0]   a_val;
   logic [CHARGE_BITS-1:0]   b_val;

   assign a_val = s1_use_a_ff ? line_rd_data[2*CHARGE_BITS-1:CHARGE_BITS] : '0;
   assign b_val = s1_use_b_ff ? line_rd_data[CHARGE_BITS-1:0] : '0;
   assign line_wr_data = {b_val, s1_x_ff};

   cmlm_ram #(
      .WIDTH (2 * CHARGE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd_data)
   );

   // ---------------------------------------------------------------- window cells
   column_type new_col;
   column_type right_col;
   column_type left_col;
   column_type center_col;

   always_comb begin
      new_col[0] = a_val;
      new_col[1] = b_val;
      new_col[2] = s1_x_ff;
      right_col  = s1_first_ff ? '0 : new_col;
   end

   cmlm_cell #(
      .CHARGE_BITS (CHARGE_BITS)
   ) u_cell_center (
      .clock   (clock),
      .shift   (s1_valid_ff),
      .kill    (1'b0),
      .col_in  (new_col),
      .col_out (center_col)
   );

   cmlm_cell #(
      .CHARGE_BITS (CHARGE_BITS)
   ) u_cell_left (
      .clock   (clock),
      .shift   (s1_valid_ff),
      .kill    (s1_first_ff),
      .col_in  (center_col),
      .col_out (left_col)
   );

   // ---------------------------------------------------------------- peak test
   // Upper row and left neighbor may tie; right neighbor and lower row may not.
   logic [CHARGE_BITS-1:0] q;
   cmlm_pkg::result_type   result;

   assign q = center_col[1];

   always_comb begin
      result.is_peak = (CmpBits'(q) > CmpBits'(qmax_cutoff_ff)) &&
                       (left_col[0]   <= q) && (center_col[0] <= q) &&
                       (right_col[0]  <= q) && (left_col[1]   <= q) &&
                       (right_col[1]  <  q) && (left_col[2]   <  q) &&
                       (center_col[2] <  q) && (right_col[2]  <  q);
      result.above_threshold = (CmpBits'(q) > CmpBits'(threshold_ff));
      result.out_row    = s1_out_row_ff;
      result.out_column = s1_out_col_ff;
   end

   // ---------------------------------------------------------------- result queue
   cmlm_pkg::result_type queue_ff [cmlm_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0]   head_ff;
   logic [PtrBits-1:0]   tail_ff;
   logic [CntBits-1:0]   count_ff;
   logic [CntBits-1:0]   count_in;
   logic                 push;
   logic                 pop;

   assign push = s1_valid_ff && s1_emit_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff + CntBits'(push) - CntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + PtrBits'(1);
         end
         if (pop) begin
            head_ff <= head_ff + PtrBits'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= result;
      end
   end

   // Accept only while the queue has room for everything in flight
   assign req_tready = (count_ff + CntBits'(s1_valid_ff)) < CntBits'(cmlm_pkg::QUEUE_DEPTH);
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[head_ff];

endmodule

// ----- rtl/core/cmlm_checker.sv -----
`include "charge_map_local_maximum_macros.svh"

module cmlm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cmlm_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A stalled response holds its value
   `CMLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // An empty block only shows a response after a request has passed the stage 1 registers and the result queue
   `CMLM_ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "response without a request")

   // Request backpressure only comes from waiting responses
   `CMLM_ASSERT_IMPLY(a_ready_cause, clock, reset, !req_tready, rsp_tvalid, "request stalled with no waiting response")

endmodule

bind charge_map_local_maximum cmlm_checker u_cmlm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
